// ===== rtl/filled_ellipse_span_generator_core_macros.svh =====
// Assertion macros shared by the ellipse span generator RTL.
`ifndef FILLED_ELLIPSE_SPAN_GENERATOR_CORE_MACROS_SVH
`define FILLED_ELLIPSE_SPAN_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define FESG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define FESG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fesg_pkg.sv =====
// Shared constants and types of the ellipse span generator.
`timescale 1ns / 1ps
package fesg_pkg;

  localparam int COORD_W     = 8;
  localparam int SEMI_W      = 4;
  localparam int MAX_SEMI    = 15;
  localparam int MAX_RESULTS = 48;
  localparam int DX_W        = 6;
  localparam int CNT_W       = 6;
  localparam int ERR_W       = 24;
  localparam int E2_W        = ERR_W + 1;
  localparam int SQ_W        = 2 * SEMI_W;
  localparam int OPA_W       = 8;
  localparam int OPB_W       = SQ_W;
  localparam int PROD_W      = OPA_W + OPB_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQW,
    ST_SQH,
    ST_INIT,
    ST_ERR,
    ST_MA,
    ST_MB,
    ST_UPD,
    ST_TIP
  } fesg_state_e;

endpackage

// ===== rtl/fesg_if.sv =====
// Valid/ready channel interfaces for ellipse commands and span results.
`timescale 1ns / 1ps
interface fesg_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [fesg_pkg::COORD_W-1:0]  center_x;
  logic [fesg_pkg::COORD_W-1:0]  center_y;
  logic [fesg_pkg::SEMI_W-1:0]   semi_w;
  logic [fesg_pkg::SEMI_W-1:0]   semi_h;

  modport source (output valid, center_x, center_y, semi_w, semi_h, input ready);
  modport sink (input valid, center_x, center_y, semi_w, semi_h, output ready);
endinterface

interface fesg_span_if;
  logic                          valid;
  logic                          ready;
  logic [fesg_pkg::COORD_W-1:0]  x_left;
  logic [fesg_pkg::COORD_W-1:0]  x_right;
  logic [fesg_pkg::COORD_W-1:0]  y_top;
  logic [fesg_pkg::COORD_W-1:0]  y_bottom;
  logic                          is_tip;
  logic                          last;

  modport source (output valid, x_left, x_right, y_top, y_bottom, is_tip, last,
                  input ready);
  modport sink (input valid, x_left, x_right, y_top, y_bottom, is_tip, last,
                output ready);
endinterface

// ===== rtl/filled_ellipse_span_generator_core.sv =====
// Top level of the filled ellipse span generator.
`timescale 1ns / 1ps
// The block takes one ellipse command (centre and two semi-axes) on cmd_i and
// returns its spans on span_o, one transfer per span, in walk order. Each
// walk span is a mirrored column pair with edge cells at y_top and y_bottom;
// after the walk, tip spans cover the remaining columns on the centre row.
// The final span of a command carries last, and a command gives 1 to 48 spans.
// A single shared multiplier, stepped by a small sequencer, does all the
// products. Setup forms the two squares, then the initial error product,
// then loads the error. Each walk span then takes two products and one
// update, each tip span only its tip step, and the first span is loaded
// into the output register by the first update after setup.
// cmd_i.ready is high only while the sequencer is idle; the last span of the
// previous command may still sit in the output register then. When span_o
// is stalled, the sequencer holds at its span-producing step until the output
// register frees, so no span is lost. Reset returns the block to idle with an
// empty output register.
module filled_ellipse_span_generator_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  fesg_cmd_if.sink     cmd_i,
  fesg_span_if.source  span_o
);
  import fesg_pkg::*;
  `include "filled_ellipse_span_generator_core_macros.svh"

  fesg_state_e state_q, state_d;

  logic [COORD_W-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [SEMI_W-1:0]  w_q, w_d, h_q, h_d;
  logic [SQ_W-1:0]    w2_q, w2_d, h2_q, h2_d;
  logic signed [PROD_W-1:0] prod_q, prod_d, prod_a_q, prod_a_d;
  logic               cond_a_q, cond_a_d;
  logic signed [ERR_W-1:0] err_q, err_d;
  logic [DX_W-1:0]    dx_q, dx_d;
  logic [SEMI_W-1:0]  dy_q, dy_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  // Output register.
  logic               out_valid_q, out_valid_d;
  logic [COORD_W-1:0] x_left_q, x_right_q, y_top_q, y_bottom_q;
  logic               is_tip_q, last_q;

  // Shared multiplier operands.
  logic signed [OPA_W-1:0]  mul_a;
  logic        [OPB_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;

  // Walk step datapath.
  logic signed [E2_W-1:0]  e2, neg_b;
  logic                    cond_a_now, cond_b;
  logic signed [ERR_W-1:0] add_a, sub_b, err_upd;
  logic [CNT_W-1:0]        cnt_inc;
  logic                    cnt_room;
  logic [DX_W-1:0]         dx_step, dx_tip;
  logic                    walk_cont, tips_follow, tip_more;
  logic [SEMI_W-1:0]       w_sat, h_sat;

  // Output load request.
  logic                    out_free, out_load;
  logic [DX_W-1:0]         ol_dx;
  logic [SEMI_W-1:0]       ol_dy;
  logic                    ol_tip, ol_last;

  fesg_mul u_mul (
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (mul_p)
  );

  // Semi-axes saturate at the largest supported value.
  assign w_sat = (cmd_i.semi_w > SEMI_W'(MAX_SEMI)) ? SEMI_W'(MAX_SEMI) : cmd_i.semi_w;
  assign h_sat = (cmd_i.semi_h > SEMI_W'(MAX_SEMI)) ? SEMI_W'(MAX_SEMI) : cmd_i.semi_h;

  assign out_free = !out_valid_q || span_o.ready;

  // The two walk conditions use twice the error before either update.
  assign e2         = $signed({err_q, 1'b0});
  assign cond_a_now = e2 < E2_W'(prod_q);
  assign neg_b      = -E2_W'(prod_q);
  assign cond_b     = e2 > neg_b;

  // The update products follow from the compare products: stepping dx adds
  // 2*h2 to (2dx+1)*h2, and stepping dy takes 2*w2 off (2dy-1)*w2.
  assign add_a   = cond_a_q ? ERR_W'(prod_a_q) + ERR_W'($signed({1'b0, h2_q, 1'b0}))
                            : '0;
  assign sub_b   = cond_b ? ERR_W'(prod_q) - ERR_W'($signed({1'b0, w2_q, 1'b0}))
                          : '0;
  assign err_upd = err_q + add_a - sub_b;

  assign cnt_inc  = CNT_W'(cnt_q + 1'b1);
  assign cnt_room = cnt_inc < CNT_W'(MAX_RESULTS);
  assign dx_step  = DX_W'(dx_q + DX_W'(cond_a_q));
  assign dx_tip   = DX_W'(dx_q + 1'b1);

  // The walk goes on while dy stays non-negative, the step moved and the span
  // cap is not reached; a step that moves neither coordinate ends it.
  assign walk_cont   = ((cond_a_q && !cond_b) || (cond_b && (dy_q != '0))) && cnt_room;
  assign tips_follow = (dx_step < DX_W'(w_q)) && cnt_room;
  assign tip_more    = (dx_tip < DX_W'(w_q)) && cnt_room;

  always_comb begin
    state_d     = state_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    w_d         = w_q;
    h_d         = h_q;
    w2_d        = w2_q;
    h2_d        = h2_q;
    prod_d      = prod_q;
    prod_a_d    = prod_a_q;
    cond_a_d    = cond_a_q;
    err_d       = err_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    cnt_d       = cnt_q;
    mul_a       = '0;
    mul_b       = '0;
    out_load    = 1'b0;
    ol_dx       = dx_q;
    ol_dy       = dy_q;
    ol_tip      = 1'b0;
    ol_last     = 1'b0;
    cmd_i.ready = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        cmd_i.ready = 1'b1;
        if (cmd_i.valid) begin
          cx_d    = cmd_i.center_x;
          cy_d    = cmd_i.center_y;
          w_d     = w_sat;
          h_d     = h_sat;
          state_d = ST_SQW;
        end
      end
      ST_SQW: begin
        mul_a   = OPA_W'(w_q);
        mul_b   = OPB_W'(w_q);
        w2_d    = OPB_W'(mul_p);
        state_d = ST_SQH;
      end
      ST_SQH: begin
        mul_a   = OPA_W'(h_q);
        mul_b   = OPB_W'(h_q);
        h2_d    = OPB_W'(mul_p);
        state_d = ST_INIT;
      end
      ST_INIT: begin
        // (2h - 1) * w2; with h at zero the factor is minus one.
        mul_a   = $signed({3'b000, h_q, 1'b0}) - OPA_W'(1);
        mul_b   = w2_q;
        prod_d  = mul_p;
        state_d = ST_ERR;
      end
      ST_ERR: begin
        err_d   = ERR_W'($signed({1'b0, h2_q})) - ERR_W'(prod_q);
        dx_d    = '0;
        dy_d    = h_q;
        cnt_d   = '0;
        state_d = ST_MA;
      end
      ST_MA: begin
        mul_a   = $signed({1'b0, dx_q, 1'b1});
        mul_b   = h2_q;
        prod_d  = mul_p;
        state_d = ST_MB;
      end
      ST_MB: begin
        cond_a_d = cond_a_now;
        prod_a_d = prod_q;
        mul_a    = $signed({3'b000, dy_q, 1'b0}) - OPA_W'(1);
        mul_b    = w2_q;
        prod_d   = mul_p;
        state_d  = ST_UPD;
      end
      ST_UPD: begin
        // Emit the span of the position before this step, then commit it.
        if (out_free) begin
          out_load = 1'b1;
          ol_dx    = dx_q;
          ol_dy    = dy_q;
          ol_tip   = 1'b0;
          ol_last  = !walk_cont && !tips_follow;
          err_d    = err_upd;
          dx_d     = dx_step;
          if (cond_b && (dy_q != '0)) begin
            dy_d = SEMI_W'(dy_q - 1'b1);
          end
          cnt_d = cnt_inc;
          if (walk_cont) begin
            state_d = ST_MA;
          end else if (tips_follow) begin
            state_d = ST_TIP;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_TIP: begin
        if (out_free) begin
          out_load = 1'b1;
          ol_dx    = dx_tip;
          ol_dy    = '0;
          ol_tip   = 1'b1;
          ol_last  = !tip_more;
          dx_d     = dx_tip;
          cnt_d    = cnt_inc;
          state_d  = tip_more ? ST_TIP : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (span_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q     <= cx_d;
    cy_q     <= cy_d;
    w_q      <= w_d;
    h_q      <= h_d;
    w2_q     <= w2_d;
    h2_q     <= h2_d;
    prod_q   <= prod_d;
    prod_a_q <= prod_a_d;
    cond_a_q <= cond_a_d;
    err_q    <= err_d;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
  end

  // Span coordinates wrap modulo the coordinate range.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      x_left_q   <= COORD_W'(cx_q - COORD_W'(ol_dx));
      x_right_q  <= COORD_W'(cx_q + COORD_W'(ol_dx));
      y_top_q    <= COORD_W'(cy_q - COORD_W'(ol_dy));
      y_bottom_q <= COORD_W'(cy_q + COORD_W'(ol_dy));
      is_tip_q   <= ol_tip;
      last_q     <= ol_last;
    end
  end

  assign span_o.valid    = out_valid_q;
  assign span_o.x_left   = x_left_q;
  assign span_o.x_right  = x_right_q;
  assign span_o.y_top    = y_top_q;
  assign span_o.y_bottom = y_bottom_q;
  assign span_o.is_tip   = is_tip_q;
  assign span_o.last     = last_q;

  `FESG_ASSERT_NEXT(a_cmd_starts_setup, cmd_i.valid && cmd_i.ready, state_q == ST_SQW, "command transfer did not start setup")
  `FESG_ASSERT_NOW(a_span_count_bound, 1'b1, cnt_q <= CNT_W'(MAX_RESULTS), "span count exceeds limit")
  `FESG_ASSERT_NEXT(a_last_returns_idle, out_load && ol_last, state_q == ST_IDLE, "sequencer busy after last span")
  `FESG_ASSERT_NOW(a_load_needs_room, out_load, out_free, "output register overwritten")

endmodule

// ===== rtl/fesg_mul.sv =====
// Shared signed-by-unsigned multiplier used by the walk sequencer.
`timescale 1ns / 1ps
module fesg_mul (
  input  logic signed [fesg_pkg::OPA_W-1:0]  op_a_i,
  input  logic        [fesg_pkg::OPB_W-1:0]  op_b_i,
  output logic signed [fesg_pkg::PROD_W-1:0] prod_o
);
  import fesg_pkg::*;

  logic signed [OPB_W:0] op_b_s;

  assign op_b_s = $signed({1'b0, op_b_i});
  assign prod_o = PROD_W'(op_a_i) * PROD_W'(op_b_s);

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the filled ellipse span generator core.
`timescale 1ns / 1ps
module tb;
  import fesg_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0] x_left;
    logic [COORD_W-1:0] x_right;
    logic [COORD_W-1:0] y_top;
    logic [COORD_W-1:0] y_bottom;
    logic               is_tip;
    logic               last;
  } span_t;

  logic clk = 1'b0;
  logic rst_ni;

  fesg_cmd_if  cmd ();
  fesg_span_if span ();

  filled_ellipse_span_generator_core DUT (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .span_o (span)
  );

  // Spans predicted for accepted commands, oldest first.
  span_t span_fifo[$];

  // Percent chance per cycle that the sender holds back or the receiver stalls.
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;

  int unsigned failures        = 0;
  int unsigned cmds_accepted   = 0;
  int unsigned spans_checked   = 0;
  int unsigned tips_checked    = 0;
  int unsigned capped_cmds     = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The whole run should finish well inside this; a hang lands here.
  initial begin : watchdog
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic span_t make_span(input logic [COORD_W-1:0] cx,
                                      input logic [COORD_W-1:0] cy,
                                      input int dx, input int dy, input logic tip);
    span_t s;
    s.x_left   = cx - COORD_W'(dx);
    s.x_right  = cx + COORD_W'(dx);
    s.y_top    = cy - COORD_W'(dy);
    s.y_bottom = cy + COORD_W'(dy);
    s.is_tip   = tip;
    s.last     = 1'b0;
    return s;
  endfunction

  // Runs the Bresenham ellipse walk for one command and queues its spans,
  // the walk columns first and then the tips on the centre row.
  function automatic void trace_ellipse(input logic [COORD_W-1:0] cx,
                                        input logic [COORD_W-1:0] cy,
                                        input logic [SEMI_W-1:0] w_in,
                                        input logic [SEMI_W-1:0] h_in);
    int    w, h, w2, h2, dx, dy, err, e2;
    bit    moved;
    span_t s;
    span_t spans[$];
    w = w_in;
    h = h_in;
    if (w > MAX_SEMI) w = MAX_SEMI;
    if (h > MAX_SEMI) h = MAX_SEMI;
    w2  = w * w;
    h2  = h * h;
    dx  = 0;
    dy  = h;
    err = h2 - (2 * h - 1) * w2;
    do begin
      spans.push_back(make_span(cx, cy, dx, dy, 1'b0));
      e2    = 2 * err;
      moved = 1'b0;
      if (e2 < (2 * dx + 1) * h2) begin
        dx++;
        err += (2 * dx + 1) * h2;
        moved = 1'b1;
      end
      if (e2 > -(2 * dy - 1) * w2) begin
        dy--;
        err -= (2 * dy - 1) * w2;
        moved = 1'b1;
      end
      // A step that moves neither coordinate would loop forever, so it ends the walk.
      if (!moved) dy = -1;
    end while (dy >= 0 && spans.size() < MAX_RESULTS);
    while (dx < w && spans.size() < MAX_RESULTS) begin
      dx++;
      spans.push_back(make_span(cx, cy, dx, 0, 1'b1));
    end
    if (spans.size() == MAX_RESULTS) capped_cmds++;
    foreach (spans[i]) begin
      s      = spans[i];
      s.last = (i == spans.size() - 1);
      span_fifo.push_back(s);
    end
  endfunction

  task automatic compare_field(input string name, input logic [COORD_W-1:0] want,
                               input logic [COORD_W-1:0] got);
    if (got !== want) begin
      $error("span field %s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // Both channels are sampled at the rising edge: accepted commands feed the
  // predictor, accepted spans are checked against the oldest prediction.
  always @(posedge clk) begin : span_checker
    span_t want;
    if (rst_ni) begin
      if (cmd.valid && cmd.ready) begin
        cmds_accepted++;
        trace_ellipse(cmd.center_x, cmd.center_y, cmd.semi_w, cmd.semi_h);
      end
      if (span.valid && span.ready) begin
        if (span_fifo.size() == 0) begin
          $error("span transfer with no span pending: x_left %0d y_top %0d",
                 span.x_left, span.y_top);
          failures++;
        end else begin
          want = span_fifo.pop_front();
          compare_field("x_left", want.x_left, span.x_left);
          compare_field("x_right", want.x_right, span.x_right);
          compare_field("y_top", want.y_top, span.y_top);
          compare_field("y_bottom", want.y_bottom, span.y_bottom);
          compare_field("is_tip", COORD_W'(want.is_tip), COORD_W'(span.is_tip));
          compare_field("last", COORD_W'(want.last), COORD_W'(span.last));
          spans_checked++;
          if (want.is_tip) tips_checked++;
        end
      end
    end
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    span.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offers one command, with random gaps first, and returns on its transfer.
  // Valid stays high afterwards; the next call or a drain decides its level.
  task automatic send_ellipse(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                              input logic [SEMI_W-1:0] w, input logic [SEMI_W-1:0] h);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      cmd.valid <= 1'b0;
      @(negedge clk);
    end
    cmd.valid    <= 1'b1;
    cmd.center_x <= cx;
    cmd.center_y <= cy;
    cmd.semi_w   <= w;
    cmd.semi_h   <= h;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
  endtask

  task automatic send_random_ellipses(input int count);
    repeat (count) begin
      send_ellipse(COORD_W'($urandom_range(255)), COORD_W'($urandom_range(255)),
                   SEMI_W'($urandom_range(15)), SEMI_W'($urandom_range(15)));
    end
  endtask

  // Holds the command side idle until every predicted span has arrived,
  // then keeps waiting so that a stray extra span would still be caught.
  task automatic drain_spans();
    @(negedge clk);
    cmd.valid <= 1'b0;
    while (span_fifo.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic test_directed_corners();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    send_ellipse(8'd128, 8'd128, 4'd0, 4'd0);    // both semi-axes zero: one dot
    send_ellipse(8'd0, 8'd0, 4'd0, 4'd0);
    send_ellipse(8'd255, 8'd255, 4'd15, 4'd15);  // largest ellipse, wraps both ways
    send_ellipse(8'd0, 8'd0, 4'd15, 4'd15);      // wraps below zero
    send_ellipse(8'd250, 8'd5, 4'd15, 4'd15);
    send_ellipse(8'd128, 8'd128, 4'd15, 4'd0);   // flat column, then only tips
    send_ellipse(8'd128, 8'd128, 4'd0, 4'd15);   // zero width: a vertical line
    send_ellipse(8'd128, 8'd128, 4'd1, 4'd1);
    send_ellipse(8'd128, 8'd128, 4'd1, 4'd0);
    send_ellipse(8'd128, 8'd128, 4'd0, 4'd1);
    send_ellipse(8'd128, 8'd128, 4'd15, 4'd1);
    send_ellipse(8'd128, 8'd128, 4'd1, 4'd15);
    send_ellipse(8'd128, 8'd128, 4'd15, 4'd14);  // near the span cap
    send_ellipse(8'd128, 8'd128, 4'd14, 4'd15);
    send_ellipse(8'd3, 8'd252, 4'd7, 4'd9);
    send_ellipse(8'd0, 8'd255, 4'd8, 4'd8);
    send_ellipse(8'd255, 8'd0, 4'd5, 4'd12);
    send_ellipse(8'd170, 8'd85, 4'd10, 4'd5);    // alternating bit patterns
    send_ellipse(8'd85, 8'd170, 4'd5, 4'd10);
    send_ellipse(8'd127, 8'd128, 4'd2, 4'd3);
  endtask

  task automatic test_random_back_to_back();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    send_random_ellipses(30);
  endtask

  task automatic test_sender_gaps();
    sender_idle_pct = 75;
    recv_stall_pct  = 0;
    send_random_ellipses(35);
  endtask

  task automatic test_receiver_stalls();
    sender_idle_pct = 0;
    recv_stall_pct  = 75;
    send_random_ellipses(35);
  endtask

  // Mixed idling, with one full drain in the middle so the block is seen
  // starting from an empty pipeline under back-pressure.
  task automatic test_both_sides_idle();
    sender_idle_pct = 35;
    recv_stall_pct  = 35;
    send_random_ellipses(25);
    drain_spans();
    send_random_ellipses(25);
  endtask

  initial begin : test_sequence
    rst_ni       = 1'b0;
    cmd.valid    = 1'b0;
    cmd.center_x = '0;
    cmd.center_y = '0;
    cmd.semi_w   = '0;
    cmd.semi_h   = '0;
    repeat (6) @(negedge clk);
    rst_ni <= 1'b1;

    test_directed_corners();
    test_random_back_to_back();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_sides_idle();
    drain_spans();

    $display("Ran %0d ellipse commands; checked %0d spans, %0d of them tips;",
             cmds_accepted, spans_checked, tips_checked);
    $display("%0d commands hit the span cap.", capped_cmds);
    $display("Covered corner ellipses and random ones with no idling, sender gaps,");
    $display("receiver stalls and both sides idling.");
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
